### hw/rtl/qrs_pkg.sv
package qrs_pkg;

    localparam int CW      = 16;            // coefficient width
    localparam int FRAC    = 16;            // fraction bits of a root
    localparam int ROOT_W  = 40;            // root field width
    localparam int PROD_W  = 2 * CW;        // b*b and a*c
    localparam int DISC_W  = 2 * CW + 3;    // signed discriminant
    localparam int RAD_W   = 2 * CW + 2;    // radicand magnitude
    localparam int SQ_W    = RAD_W / 2;     // floor sqrt width
    localparam int SQREM_W = SQ_W + 2;      // sqrt remainder
    localparam int NUM_W   = SQ_W + 2;      // signed -b +/- s
    localparam int NMAG_W  = SQ_W + 1;      // magnitude of numerator
    localparam int DVD_W   = NMAG_W + FRAC; // dividend magnitude, also quotient
    localparam int DEN_W   = CW + 1;        // signed 2a
    localparam int DMAG_W  = CW + 1;        // magnitude of 2a

    localparam int IN_W  = 48;
    localparam int OUT_W = 88;

    localparam logic [1:0] CASE_LINEAR = 2'd0;
    localparam logic [1:0] CASE_NONE   = 2'd1;
    localparam logic [1:0] CASE_DOUBLE = 2'd2;
    localparam logic [1:0] CASE_TWO    = 2'd3;

    typedef struct packed {
        logic [1:0]               case_code;
        logic signed [DEN_W-1:0]  negb;
        logic signed [DEN_W-1:0]  den;
    } sq_tag_t;

    typedef struct packed {
        logic [1:0]        case_code;
        logic              neg_p;
        logic              neg_m;
        logic [DVD_W-1:0]  mag_p;
        logic [DVD_W-1:0]  mag_m;
    } div_out_t;

endpackage

### hw/rtl/qrs_front.sv
module qrs_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [qrs_pkg::CW-1:0]       coef_a,
    input  logic signed [qrs_pkg::CW-1:0]       coef_b,
    input  logic signed [qrs_pkg::CW-1:0]       coef_c,
    output logic                                out_valid,
    output logic [qrs_pkg::RAD_W-1:0]           out_rad,
    output qrs_pkg::sq_tag_t                    out_tag
);

    logic                                 v1_reg;
    logic signed [qrs_pkg::PROD_W-1:0]    bb_reg;
    logic signed [qrs_pkg::PROD_W-1:0]    ac_reg;
    logic signed [qrs_pkg::CW-1:0]        a_reg;
    logic signed [qrs_pkg::CW-1:0]        b_reg;

    logic                                 v2_reg;
    logic [qrs_pkg::RAD_W-1:0]            rad_reg;
    logic [qrs_pkg::RAD_W-1:0]            rad_next;
    qrs_pkg::sq_tag_t                     tag_reg;
    qrs_pkg::sq_tag_t                     tag_next;
    logic signed [qrs_pkg::DISC_W-1:0]    disc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb_reg  <= coef_b * coef_b;
            ac_reg  <= coef_a * coef_c;
            a_reg   <= coef_a;
            b_reg   <= coef_b;
            rad_reg <= rad_next;
            tag_reg <= tag_next;
        end
    end

    // exact b*b - 4ac
    assign disc = {{3{bb_reg[qrs_pkg::PROD_W-1]}}, bb_reg}
                - {ac_reg[qrs_pkg::PROD_W-1], ac_reg, 2'b00};

    always_comb begin
        tag_next.negb = -{b_reg[qrs_pkg::CW-1], b_reg};
        tag_next.den  = {a_reg, 1'b0};
        rad_next      = '0;
        if (a_reg == '0) begin
            tag_next.case_code = qrs_pkg::CASE_LINEAR;
        end else if (disc[qrs_pkg::DISC_W-1]) begin
            tag_next.case_code = qrs_pkg::CASE_NONE;
        end else if (disc == '0) begin
            tag_next.case_code = qrs_pkg::CASE_DOUBLE;
        end else begin
            tag_next.case_code = qrs_pkg::CASE_TWO;
            rad_next           = disc[qrs_pkg::RAD_W-1:0];
        end
    end

    assign out_valid = v2_reg;
    assign out_rad   = rad_reg;
    assign out_tag   = tag_reg;

endmodule

### hw/rtl/qrs_sqrt.sv
module qrs_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [qrs_pkg::RAD_W-1:0]      in_rad,
    input  qrs_pkg::sq_tag_t               in_tag,
    output logic                           out_valid,
    output logic [qrs_pkg::SQ_W-1:0]       out_root,
    output qrs_pkg::sq_tag_t               out_tag
);

    localparam int N = qrs_pkg::SQ_W;

    logic                             v_reg   [0:N];
    logic [qrs_pkg::RAD_W-1:0]        rad_reg [0:N];
    logic [qrs_pkg::SQREM_W-1:0]      rem_reg [0:N];
    logic [qrs_pkg::SQ_W-1:0]         root_reg[0:N];
    qrs_pkg::sq_tag_t                 tag_reg [0:N];

    always_comb begin
        v_reg[0]    = in_valid;
        rad_reg[0]  = in_rad;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        tag_reg[0]  = in_tag;
    end

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar i = 0; i < N; i++) begin : g_step
        logic [qrs_pkg::SQREM_W+1:0] rem_sh;
        logic [qrs_pkg::SQREM_W+1:0] trial;
        logic                        fits;

        assign rem_sh = {rem_reg[i], rad_reg[i][qrs_pkg::RAD_W-1 -: 2]};
        assign trial  = {1'b0, 1'b0, root_reg[i], 2'b01};
        assign fits   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i+1]  <= {rad_reg[i][qrs_pkg::RAD_W-3:0], 2'b00};
                rem_reg[i+1]  <= fits ? qrs_pkg::SQREM_W'(rem_sh - trial)
                                      : qrs_pkg::SQREM_W'(rem_sh);
                root_reg[i+1] <= {root_reg[i][qrs_pkg::SQ_W-2:0], fits};
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_root  = root_reg[N];
    assign out_tag   = tag_reg[N];

endmodule

### hw/rtl/qrs_div.sv
module qrs_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [qrs_pkg::SQ_W-1:0]            in_root,
    input  qrs_pkg::sq_tag_t                    in_tag,
    output logic                                out_valid,
    output qrs_pkg::div_out_t                   out_res
);

    localparam int N = qrs_pkg::DVD_W;

    logic signed [qrs_pkg::NUM_W-1:0]   num_p;
    logic signed [qrs_pkg::NUM_W-1:0]   num_m;
    logic [qrs_pkg::NMAG_W-1:0]         nmag_p;
    logic [qrs_pkg::NMAG_W-1:0]         nmag_m;
    logic [qrs_pkg::DMAG_W-1:0]         dmag;
    logic                               den_neg;

    logic                         v_reg   [0:N];
    logic [1:0]                   cc_reg  [0:N];
    logic                         np_reg  [0:N];
    logic                         nm_reg  [0:N];
    logic [qrs_pkg::DMAG_W-1:0]   dv_reg  [0:N];
    logic [qrs_pkg::DVD_W-1:0]    qp_reg  [0:N];
    logic [qrs_pkg::DVD_W-1:0]    qm_reg  [0:N];
    logic [qrs_pkg::DMAG_W-1:0]   rp_reg  [0:N];
    logic [qrs_pkg::DMAG_W-1:0]   rm_reg  [0:N];

    assign num_p   = {{2{in_tag.negb[qrs_pkg::DEN_W-1]}}, in_tag.negb}
                   + qrs_pkg::NUM_W'(in_root);
    assign num_m   = {{2{in_tag.negb[qrs_pkg::DEN_W-1]}}, in_tag.negb}
                   - qrs_pkg::NUM_W'(in_root);
    assign nmag_p  = qrs_pkg::NMAG_W'(num_p[qrs_pkg::NUM_W-1] ? -num_p : num_p);
    assign nmag_m  = qrs_pkg::NMAG_W'(num_m[qrs_pkg::NUM_W-1] ? -num_m : num_m);
    assign den_neg = in_tag.den[qrs_pkg::DEN_W-1];
    assign dmag    = den_neg ? qrs_pkg::DMAG_W'(-in_tag.den)
                             : qrs_pkg::DMAG_W'(in_tag.den);

    // entry stage: magnitudes and quotient signs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cc_reg[0] <= in_tag.case_code;
            np_reg[0] <= num_p[qrs_pkg::NUM_W-1] ^ den_neg;
            nm_reg[0] <= num_m[qrs_pkg::NUM_W-1] ^ den_neg;
            dv_reg[0] <= dmag;
            qp_reg[0] <= {nmag_p, {qrs_pkg::FRAC{1'b0}}};
            qm_reg[0] <= {nmag_m, {qrs_pkg::FRAC{1'b0}}};
            rp_reg[0] <= '0;
            rm_reg[0] <= '0;
        end
    end

    // restoring division, one quotient bit per stage for both lanes;
    // the dividend shifts out of q while quotient bits shift in
    for (genvar i = 0; i < N; i++) begin : g_step
        logic [qrs_pkg::DMAG_W:0] sh_p;
        logic [qrs_pkg::DMAG_W:0] sh_m;
        logic                     ge_p;
        logic                     ge_m;

        assign sh_p = {rp_reg[i], qp_reg[i][qrs_pkg::DVD_W-1]};
        assign sh_m = {rm_reg[i], qm_reg[i][qrs_pkg::DVD_W-1]};
        assign ge_p = sh_p >= {1'b0, dv_reg[i]};
        assign ge_m = sh_m >= {1'b0, dv_reg[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cc_reg[i+1] <= cc_reg[i];
                np_reg[i+1] <= np_reg[i];
                nm_reg[i+1] <= nm_reg[i];
                dv_reg[i+1] <= dv_reg[i];
                rp_reg[i+1] <= ge_p ? qrs_pkg::DMAG_W'(sh_p - {1'b0, dv_reg[i]})
                                    : qrs_pkg::DMAG_W'(sh_p);
                rm_reg[i+1] <= ge_m ? qrs_pkg::DMAG_W'(sh_m - {1'b0, dv_reg[i]})
                                    : qrs_pkg::DMAG_W'(sh_m);
                qp_reg[i+1] <= {qp_reg[i][qrs_pkg::DVD_W-2:0], ge_p};
                qm_reg[i+1] <= {qm_reg[i][qrs_pkg::DVD_W-2:0], ge_m};
            end
        end
    end

    assign out_valid         = v_reg[N];
    assign out_res.case_code = cc_reg[N];
    assign out_res.neg_p     = np_reg[N];
    assign out_res.neg_m     = nm_reg[N];
    assign out_res.mag_p     = qp_reg[N];
    assign out_res.mag_m     = qm_reg[N];

endmodule

### hw/rtl/quadratic_root_solver.sv
// channel | dir | beat contents (tdata, lowest bit first)
// s_axis  | in  | coef_a[15:0], coef_b[31:16], coef_c[47:32]
// m_axis  | out | case_code[1:0], root_plus[41:2], root_minus[81:42], zero pad
//
// One beat per cycle sustained while the output does not stall. In order, the stages are products
// and discriminant, sqrt (one root bit per stage), numerators, divider (one quotient
// bit per stage) and the output register.
// aresetn (synchronous) clears all valid bits; data registers are not reset.
// The whole pipeline holds while m_tvalid is high and m_tready low.
module quadratic_root_solver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [qrs_pkg::IN_W-1:0]    s_tdata,   // coef_a, coef_b, coef_c
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [qrs_pkg::OUT_W-1:0]   m_tdata    // case_code, root_plus, root_minus
);

    logic                          en;
    logic                          fr_valid;
    logic [qrs_pkg::RAD_W-1:0]     fr_rad;
    qrs_pkg::sq_tag_t              fr_tag;
    logic                          sq_valid;
    logic [qrs_pkg::SQ_W-1:0]      sq_root;
    qrs_pkg::sq_tag_t              sq_tag;
    logic                          dv_valid;
    qrs_pkg::div_out_t             dv_res;

    logic                                  m_tvalid_reg;
    logic [1:0]                            case_reg;
    logic [1:0]                            case_next;
    logic signed [qrs_pkg::ROOT_W-1:0]     rp_reg;
    logic signed [qrs_pkg::ROOT_W-1:0]     rp_next;
    logic signed [qrs_pkg::ROOT_W-1:0]     rm_reg;
    logic signed [qrs_pkg::ROOT_W-1:0]     rm_next;
    logic                                  has_roots;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    qrs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .coef_a    (s_tdata[15:0]),
        .coef_b    (s_tdata[31:16]),
        .coef_c    (s_tdata[47:32]),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_tag   (fr_tag)
    );

    qrs_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_tag    (fr_tag),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    qrs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_tag    (sq_tag),
        .out_valid (dv_valid),
        .out_res   (dv_res)
    );

    assign has_roots = dv_res.case_code == qrs_pkg::CASE_DOUBLE
                    || dv_res.case_code == qrs_pkg::CASE_TWO;

    always_comb begin
        case_next = dv_res.case_code;
        rp_next   = '0;
        rm_next   = '0;
        if (has_roots) begin
            rp_next = dv_res.neg_p ? -qrs_pkg::ROOT_W'(dv_res.mag_p)
                                   :  qrs_pkg::ROOT_W'(dv_res.mag_p);
            rm_next = dv_res.neg_m ? -qrs_pkg::ROOT_W'(dv_res.mag_m)
                                   :  qrs_pkg::ROOT_W'(dv_res.mag_m);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            case_reg <= case_next;
            rp_reg   <= rp_next;
            rm_reg   <= rm_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, rm_reg, rp_reg, case_reg};

    a_no_root_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (case_reg == qrs_pkg::CASE_LINEAR || case_reg == qrs_pkg::CASE_NONE)
        |-> rp_reg == '0 && rm_reg == '0)
        else $error("roots not zero without real roots");

    a_double_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && case_reg == qrs_pkg::CASE_DOUBLE |-> rp_reg == rm_reg)
        else $error("double root fields differ");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(case_reg) && $stable(rp_reg) && $stable(dv_valid))
        else $error("pipeline moved during stall");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY = 55;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic [1:0]  case_code;
        logic [39:0] root_plus;
        logic [39:0] root_minus;
    } roots_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [qrs_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [qrs_pkg::OUT_W-1:0] m_tdata;

    roots_t expected_roots[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int idle_cycles = 0;
    int n_case[4] = '{0, 0, 0, 0};

    quadratic_root_solver u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // truncating divide scaled by 2^FRAC, saturated to 40 bits
    function automatic logic [39:0] scaled_quotient(longint num, longint den);
        longint q;
        q = (num * (longint'(1) <<< qrs_pkg::FRAC)) / den;
        if (q > (longint'(1) <<< 39) - 1) q = (longint'(1) <<< 39) - 1;
        if (q < -(longint'(1) <<< 39)) q = -(longint'(1) <<< 39);
        return q[39:0];
    endfunction

    function automatic logic [35:0] floor_sqrt(logic [35:0] v);
        logic [35:0] root;
        logic [37:0] rem;
        logic [37:0] trial;
        root = '0;
        rem = '0;
        for (int i = 17; i >= 0; i--) begin
            rem = (rem << 2) | v[2*i +: 2];
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic roots_t solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                           logic signed [15:0] c);
        roots_t r;
        longint disc, s;
        r.case_code = qrs_pkg::CASE_LINEAR;
        r.root_plus = '0;
        r.root_minus = '0;
        if (a == 0) return r;
        disc = longint'(b) * b - 4 * longint'(a) * c;
        if (disc < 0) begin
            r.case_code = qrs_pkg::CASE_NONE;
        end else if (disc == 0) begin
            r.case_code = qrs_pkg::CASE_DOUBLE;
            r.root_plus = scaled_quotient(-longint'(b), 2 * longint'(a));
            r.root_minus = r.root_plus;
        end else begin
            s = longint'(floor_sqrt(disc[35:0]));
            r.case_code = qrs_pkg::CASE_TWO;
            r.root_plus = scaled_quotient(-longint'(b) + s, 2 * longint'(a));
            r.root_minus = scaled_quotient(-longint'(b) - s, 2 * longint'(a));
        end
        return r;
    endfunction

    // s_tvalid stays high between back-to-back beats; it drops only for a gap
    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_roots.push_back(solve_roots(a, b, c));
        sent++;
    endtask

    // result side: random stalls, then check each beat
    initial begin
        roots_t exp_r;
        int stall;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            received++;
            if (expected_roots.size() == 0) begin
                $error("unexpected result beat %h", m_tdata);
                errors++;
            end else begin
                exp_r = expected_roots.pop_front();
                n_case[exp_r.case_code]++;
                if (m_tdata[1:0] !== exp_r.case_code) begin
                    $error("case_code exp %0d got %0d", exp_r.case_code, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[41:2] !== exp_r.root_plus) begin
                    $error("root_plus exp %h got %h", exp_r.root_plus, m_tdata[41:2]);
                    errors++;
                end
                if (m_tdata[81:42] !== exp_r.root_minus) begin
                    $error("root_minus exp %h got %h", exp_r.root_minus, m_tdata[81:42]);
                    errors++;
                end
            end
        end
    end

    // watchdog on beats at either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout, %0d results outstanding", expected_roots.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_roots.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        logic [15:0] vals[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        foreach (vals[i]) send_coefs(vals[i], vals[(i + 1) % 5], vals[(i + 3) % 5]);
        send_coefs(16'h8000, 16'h8000, 16'h7fff);   // largest discriminant
        send_coefs(16'h7fff, 16'h8000, 16'h8000);
        send_coefs(16'h0001, 16'h0000, 16'h8000);
    endtask

    task automatic test_cases();
        send_coefs(16'd0, 16'd5, 16'd3);              // linear
        send_coefs(16'd1, 16'd0, 16'd1);              // no real roots
        send_coefs(16'd1, 16'd2, 16'd1);              // double root
        send_coefs(-16'sd3, 16'd12, -16'sd12);        // double, negative a
        send_coefs(16'd1, -16'sd3, 16'd2);            // two roots
        send_coefs(16'd2, 16'd1, -16'sd1);            // non-integer root
        send_coefs(-16'sd7, 16'd3, 16'd11);
        send_coefs(16'd1, 16'd1, 16'd0);              // c zero
    endtask

    task automatic test_random(int count);
        logic [15:0] a, b, c, k, r;
        for (int i = 0; i < count; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            c = 16'($urandom);
            case ($urandom_range(0, 7))
                0: a = 16'd0;
                1: begin   // force a perfect square: b = 2ak, c = ak^2
                    a = 16'($urandom_range(1, 15) * ($urandom_range(0, 1) ? 1 : -1));
                    k = 16'($urandom_range(0, 60) - 30);
                    b = 16'(2 * a * k);
                    c = a * k * k;
                end
                2: begin   // small coefficients
                    a = 16'($urandom_range(0, 20) - 10);
                    b = 16'($urandom_range(0, 40) - 20);
                    c = 16'($urandom_range(0, 20) - 10);
                end
                3: begin   // roots from factors: (x - r)(x - k)
                    r = 16'($urandom_range(0, 200) - 100);
                    k = 16'($urandom_range(0, 200) - 100);
                    a = 16'd1;
                    b = -(r + k);
                    c = r * k;
                end
                default: ;
            endcase
            send_coefs(a, b, c);
            if (i == count / 2) drain_pipeline();   // sender holds off until empty
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_cases();
        test_extremes();
        test_random(1100);
        drain_pipeline();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("%0d coefficient sets sent, %0d results checked", sent, received);
        $display("linear %0d, no roots %0d, double %0d, two roots %0d",
                 n_case[0], n_case[1], n_case[2], n_case[3]);
        if (errors == 0 && expected_roots.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
